// ----- hdl/kci_pkg.sv -----
`default_nettype none
package kci_pkg;

  // divider geometry
  localparam int DIV_N_W  = 48;
  localparam int DIV_D_W  = 32;
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 6'd47;

  // fixed point constants, Q16.16
  localparam logic [31:0] ONE_Q = 32'h0001_0000;
  localparam logic [31:0] FOV90 = 32'h005A_0000;
  localparam logic signed [33:0] DEG180 = 34'sd11796480;
  localparam logic [17:0] THREE_Q = 18'd196608;
  // floor(x/360) ~= (x*RECIP360) >> 22 for x < 2^18, at most one high
  localparam logic [13:0] RECIP360 = 14'd11651;
  localparam logic [8:0]  DEG360_INT = 9'd360;

  // item commands
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_ADD     = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;
  localparam logic [1:0] CMD_RESTART = 2'd3;

  // config register indexes
  localparam logic [1:0] REG_ENABLE     = 2'd0;
  localparam logic [1:0] REG_LOOP_MODE  = 2'd1;
  localparam logic [1:0] REG_CYCLE_TIME = 2'd2;
  localparam logic [1:0] REG_SPEED      = 2'd3;

  // pose channels
  localparam logic [2:0] CH_PITCH = 3'd3;
  localparam logic [2:0] CH_ROLL  = 3'd5;
  localparam logic [2:0] CH_FOV   = 3'd6;

  // datapath operations
  localparam logic [4:0] OP_NONE      = 5'd0;
  localparam logic [4:0] OP_LOAD      = 5'd1;
  localparam logic [4:0] OP_ADD       = 5'd2;
  localparam logic [4:0] OP_CLEAR     = 5'd3;
  localparam logic [4:0] OP_RESTART   = 5'd4;
  localparam logic [4:0] OP_MUL       = 5'd5;
  localparam logic [4:0] OP_ACC       = 5'd6;
  localparam logic [4:0] OP_DIVT      = 5'd7;
  localparam logic [4:0] OP_TREM      = 5'd8;
  localparam logic [4:0] OP_CLAMP     = 5'd9;
  localparam logic [4:0] OP_RD0       = 5'd10;
  localparam logic [4:0] OP_POSE_KEY  = 5'd11;
  localparam logic [4:0] OP_SRCH_INIT = 5'd12;
  localparam logic [4:0] OP_RDNEXT    = 5'd13;
  localparam logic [4:0] OP_SRCH_INC  = 5'd14;
  localparam logic [4:0] OP_SETB      = 5'd15;
  localparam logic [4:0] OP_RDA       = 5'd16;
  localparam logic [4:0] OP_RDB       = 5'd17;
  localparam logic [4:0] OP_CAPB      = 5'd18;
  localparam logic [4:0] OP_SETUP     = 5'd19;
  localparam logic [4:0] OP_SDIRECT   = 5'd20;
  localparam logic [4:0] OP_DIVS      = 5'd21;
  localparam logic [4:0] OP_SQUO      = 5'd22;
  localparam logic [4:0] OP_SM1       = 5'd23;
  localparam logic [4:0] OP_SM2       = 5'd24;
  localparam logic [4:0] OP_CH_D      = 5'd25;
  localparam logic [4:0] OP_CH_Q      = 5'd26;
  localparam logic [4:0] OP_CH_W      = 5'd27;
  localparam logic [4:0] OP_CH_MUL    = 5'd28;
  localparam logic [4:0] OP_CH_WR     = 5'd29;

  typedef struct packed {
    logic [6:0][31:0] v;   // x, y, z, pitch, yaw, roll, fov
    logic [31:0]      t;
  } kci_key_t;

  typedef struct packed {
    logic [4:0] op;
  } kci_cmd_t;

  typedef struct packed {
    logic [1:0] item_cmd;
    logic       enable;
    logic       loop_mode;
    logic       div_fin;
    logic       n_zero;
    logic       n_one;
    logic       srch_end;
    logic       t_lt;
    logic       s_direct;
    logic       ch_last;
  } kci_stat_t;

endpackage
`default_nettype wire

// ----- hdl/kci_div.sv -----
`default_nettype none
module kci_div import kci_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [DIV_N_W-1:0] dividend,
  input  wire logic [DIV_D_W-1:0] divisor,
  output logic                    fin,
  output logic [DIV_N_W-1:0]      quo,
  output logic [DIV_D_W-1:0]      rem
);

  // restoring divider, one quotient bit per cycle
  logic                 run;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_D_W-1:0]   dsr;
  logic [DIV_D_W:0]     shifted;
  logic                 fits;

  assign shifted = {rem, quo[DIV_N_W-1]};
  assign fits    = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == DIV_LAST) begin
        run <= 1'b0;
        fin <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
      cnt <= '0;
    end else if (run) begin
      rem <= fits ? DIV_D_W'(shifted - {1'b0, dsr}) : shifted[DIV_D_W-1:0];
      quo <= {quo[DIV_N_W-2:0], fits};
      cnt <= cnt + 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/kci_ctrl.sv -----
`default_nettype none
module kci_ctrl import kci_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire kci_stat_t stat,
  output kci_cmd_t       ctl,
  output logic           busy,
  output logic           done
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DISPATCH = 5'd1;
  localparam logic [4:0] S_ACC      = 5'd2;
  localparam logic [4:0] S_TIME     = 5'd3;
  localparam logic [4:0] S_DIVT     = 5'd4;
  localparam logic [4:0] S_KEYS     = 5'd5;
  localparam logic [4:0] S_ONE      = 5'd6;
  localparam logic [4:0] S_SRD      = 5'd7;
  localparam logic [4:0] S_SCMP     = 5'd8;
  localparam logic [4:0] S_RDA      = 5'd9;
  localparam logic [4:0] S_RDB      = 5'd10;
  localparam logic [4:0] S_CAPB     = 5'd11;
  localparam logic [4:0] S_SETUP    = 5'd12;
  localparam logic [4:0] S_SDEC     = 5'd13;
  localparam logic [4:0] S_DIVS     = 5'd14;
  localparam logic [4:0] S_SM1      = 5'd15;
  localparam logic [4:0] S_SM2      = 5'd16;
  localparam logic [4:0] S_CH_D     = 5'd17;
  localparam logic [4:0] S_CH_Q     = 5'd18;
  localparam logic [4:0] S_CH_W     = 5'd19;
  localparam logic [4:0] S_CH_MUL   = 5'd20;
  localparam logic [4:0] S_CH_WR    = 5'd21;
  localparam logic [4:0] S_DONE     = 5'd22;

  logic [4:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl.op     = OP_NONE;
    unique case (state)
      S_IDLE: if (start) begin
        ctl.op     = OP_LOAD;
        state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        state_next = S_DONE;
        unique case (stat.item_cmd)
          CMD_TICK: if (stat.enable) begin
            ctl.op     = OP_MUL;
            state_next = S_ACC;
          end
          CMD_ADD:     ctl.op = OP_ADD;
          CMD_CLEAR:   ctl.op = OP_CLEAR;
          CMD_RESTART: ctl.op = OP_RESTART;
        endcase
      end
      S_ACC: begin
        ctl.op     = OP_ACC;
        state_next = S_TIME;
      end
      S_TIME: if (stat.loop_mode) begin
        ctl.op     = OP_DIVT;
        state_next = S_DIVT;
      end else begin
        ctl.op     = OP_CLAMP;
        state_next = S_KEYS;
      end
      S_DIVT: if (stat.div_fin) begin
        ctl.op     = OP_TREM;
        state_next = S_KEYS;
      end
      S_KEYS: priority if (stat.n_zero) begin
        state_next = S_DONE;
      end else if (stat.n_one) begin
        ctl.op     = OP_RD0;
        state_next = S_ONE;
      end else begin
        ctl.op     = OP_SRCH_INIT;
        state_next = S_SRD;
      end
      S_ONE: begin
        ctl.op     = OP_POSE_KEY;
        state_next = S_DONE;
      end
      S_SRD: if (stat.srch_end) begin
        ctl.op     = OP_SETB;
        state_next = S_RDA;
      end else begin
        ctl.op     = OP_RDNEXT;
        state_next = S_SCMP;
      end
      S_SCMP: if (stat.t_lt) begin
        ctl.op     = OP_SETB;
        state_next = S_RDA;
      end else begin
        ctl.op     = OP_SRCH_INC;
        state_next = S_SRD;
      end
      S_RDA: begin
        ctl.op     = OP_RDA;
        state_next = S_RDB;
      end
      S_RDB: begin
        ctl.op     = OP_RDB;
        state_next = S_CAPB;
      end
      S_CAPB: begin
        ctl.op     = OP_CAPB;
        state_next = S_SETUP;
      end
      S_SETUP: begin
        ctl.op     = OP_SETUP;
        state_next = S_SDEC;
      end
      S_SDEC: if (stat.s_direct) begin
        ctl.op     = OP_SDIRECT;
        state_next = S_SM1;
      end else begin
        ctl.op     = OP_DIVS;
        state_next = S_DIVS;
      end
      S_DIVS: if (stat.div_fin) begin
        ctl.op     = OP_SQUO;
        state_next = S_SM1;
      end
      S_SM1: begin
        ctl.op     = OP_SM1;
        state_next = S_SM2;
      end
      S_SM2: begin
        ctl.op     = OP_SM2;
        state_next = S_CH_D;
      end
      S_CH_D: begin
        ctl.op     = OP_CH_D;
        state_next = S_CH_Q;
      end
      S_CH_Q: begin
        ctl.op     = OP_CH_Q;
        state_next = S_CH_W;
      end
      S_CH_W: begin
        ctl.op     = OP_CH_W;
        state_next = S_CH_MUL;
      end
      S_CH_MUL: begin
        ctl.op     = OP_CH_MUL;
        state_next = S_CH_WR;
      end
      S_CH_WR: begin
        ctl.op     = OP_CH_WR;
        state_next = stat.ch_last ? S_DONE : S_CH_D;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = state != S_IDLE;
  assign done = state == S_DONE;

endmodule
`default_nettype wire

// ----- hdl/kci_dp.sv -----
`default_nettype none
module kci_dp import kci_pkg::*; #(
  parameter int MAX_KEYS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire kci_cmd_t           ctl,
  output kci_stat_t               stat,
  input  wire logic               wr_en,
  input  wire logic [1:0]         wr_index,
  input  wire logic [31:0]        wr_data,
  input  wire logic [1:0]         cmd,
  input  wire logic [23:0]        frame_time,
  input  wire logic signed [31:0] key_x,
  input  wire logic signed [31:0] key_y,
  input  wire logic signed [31:0] key_z,
  input  wire logic signed [31:0] key_pitch,
  input  wire logic signed [31:0] key_yaw,
  input  wire logic signed [31:0] key_roll,
  input  wire logic signed [31:0] key_fov,
  input  wire logic [31:0]        key_time,
  output logic signed [31:0]      pos_x,
  output logic signed [31:0]      pos_y,
  output logic signed [31:0]      pos_z,
  output logic signed [31:0]      out_pitch,
  output logic signed [31:0]      out_yaw,
  output logic signed [31:0]      out_roll,
  output logic signed [31:0]      out_fov,
  output logic [3:0]              slot_index,
  output logic                    add_ok
);

  localparam int KW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);

  // config
  logic        enable, loop_mode;
  logic [31:0] cycle_time;
  logic [15:0] speed;
  logic [31:0] cyc;

  // control state
  logic [CW-1:0]    key_count;
  logic [47:0]      acc;
  logic [6:0][31:0] pose;
  logic [3:0]       slot;
  logic             ok;

  // latched item
  logic [1:0]  item_cmd;
  logic [23:0] ft;
  kci_key_t    nk;

  // key memory
  kci_key_t mem [MAX_KEYS];
  kci_key_t rd_key;
  logic [KW-1:0] rd_addr;

  // work registers
  logic [39:0]        prod;
  logic [31:0]        t;
  logic [KW-1:0]      a, b;
  kci_key_t           ka, kb;
  logic [31:0]        dur_r;
  logic signed [32:0] num_r;
  logic [16:0]        s, s2, sm;
  logic [2:0]         ch;
  logic signed [32:0] d_r, dw_r;
  logic               wpos, wneg;
  logic [17:0]        x_r;
  logic [9:0]         qe;
  logic signed [50:0] prodc;

  // divider
  logic               div_start, div_fin;
  logic [DIV_N_W-1:0] div_num, div_quo;
  logic [DIV_D_W-1:0] div_den, div_rem;

  kci_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .fin      (div_fin),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  assign cyc       = (cycle_time == '0) ? ONE_Q : cycle_time;
  assign div_start = (ctl.op == OP_DIVT) || (ctl.op == OP_DIVS);
  assign div_num   = (ctl.op == OP_DIVT) ? acc : {num_r[31:0], 16'h0000};
  assign div_den   = (ctl.op == OP_DIVT) ? cyc : dur_r;

  logic          full;
  logic [CW:0]   a_p1;
  assign full = key_count == CW'(MAX_KEYS);
  assign a_p1 = (CW+1)'(a) + 1'b1;

  // combinational helpers
  logic [48:0]        acc_sum;
  logic [31:0]        tb;
  logic signed [32:0] dur_c, num_c;
  logic [33:0]        sq;
  logic [34:0]        smp;
  logic [17:0]        fac;
  logic signed [31:0] va, vb;
  logic signed [32:0] d_c;
  logic               ang, pos_c, neg_c;
  logic signed [33:0] m_c;
  logic [31:0]        qx;
  logic [18:0]        q360;
  logic signed [35:0] adj, dw_c;
  logic signed [35:0] sum_c;
  logic signed [31:0] sat_c;

  always_comb begin
    acc_sum = {1'b0, acc} + 49'(prod[39:8]);
    tb      = (b == '0 && loop_mode) ? cyc : kb.t;
    dur_c   = $signed({1'b0, tb}) - $signed({1'b0, ka.t});
    num_c   = $signed({1'b0, t}) - $signed({1'b0, ka.t});
    sq      = s * s;
    fac     = THREE_Q - {s, 1'b0};
    smp     = s2 * fac;
    va      = $signed(ka.v[ch]);
    vb      = $signed(kb.v[ch]);
    d_c     = 33'(vb) - 33'(va);
    ang     = (ch >= CH_PITCH) && (ch <= CH_ROLL);
    pos_c   = ang && (34'(d_c) > DEG180);
    neg_c   = ang && (34'(d_c) < -DEG180);
    m_c     = (neg_c ? -34'(d_c) : 34'(d_c)) + DEG180 - 34'sd1;
    qx      = x_r * RECIP360;
    q360    = qe * DEG360_INT;
    if (x_r < q360) begin
      q360 = q360 - 19'(DEG360_INT);
    end
    adj     = $signed({1'b0, q360, 16'h0000});
    priority if (wpos) begin
      dw_c = 36'(d_r) - adj;
    end else if (wneg) begin
      dw_c = 36'(d_r) + adj;
    end else begin
      dw_c = 36'(d_r);
    end
    sum_c   = 36'(va) + 36'($signed(prodc[50:16]));
    priority if (sum_c > 36'sd2147483647) begin
      sat_c = 32'sh7FFF_FFFF;
    end else if (sum_c < -36'sd2147483648) begin
      sat_c = 32'sh8000_0000;
    end else begin
      sat_c = sum_c[31:0];
    end
  end

  always_comb begin
    unique case (ctl.op)
      OP_RD0:    rd_addr = '0;
      OP_RDNEXT: rd_addr = a_p1[KW-1:0];
      OP_RDB:    rd_addr = b;
      default:   rd_addr = a;
    endcase
  end

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      loop_mode  <= 1'b1;
      cycle_time <= 32'd1966080;
      speed      <= 16'd256;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ENABLE:     enable     <= wr_data[0];
        REG_LOOP_MODE:  loop_mode  <= wr_data[0];
        REG_CYCLE_TIME: cycle_time <= wr_data;
        REG_SPEED:      speed      <= wr_data[15:0];
      endcase
    end
  end

  // key table
  always_ff @(posedge clk) begin
    if (ctl.op == OP_ADD && !full) begin
      mem[key_count[KW-1:0]] <= nk;
    end
    rd_key <= mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= '0;
      acc       <= '0;
      pose      <= {FOV90, {6{32'h0}}};
      slot      <= '0;
      ok        <= 1'b0;
    end else begin
      unique case (ctl.op)
        OP_LOAD: begin
          slot <= '0;
          ok   <= 1'b0;
        end
        OP_ADD: if (!full) begin
          slot      <= 4'(key_count);
          ok        <= 1'b1;
          key_count <= key_count + 1'b1;
        end
        OP_CLEAR:    key_count <= '0;
        OP_RESTART:  acc <= '0;
        OP_ACC:      acc <= acc_sum[48] ? '1 : acc_sum[47:0];
        OP_POSE_KEY: pose <= rd_key.v;
        OP_CH_WR:    pose[ch] <= sat_c;
        default: ;
      endcase
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_LOAD: begin
        item_cmd <= cmd;
        ft       <= frame_time;
        nk.v[0]  <= key_x;
        nk.v[1]  <= key_y;
        nk.v[2]  <= key_z;
        nk.v[3]  <= key_pitch;
        nk.v[4]  <= key_yaw;
        nk.v[5]  <= key_roll;
        nk.v[6]  <= (key_fov <= 32'sd0) ? FOV90 : key_fov;
        nk.t     <= key_time;
      end
      OP_MUL:       prod <= ft * speed;
      OP_CLAMP:     t <= (acc > 48'(cyc)) ? cyc : acc[31:0];
      OP_TREM:      t <= div_rem;
      OP_SRCH_INIT: a <= '0;
      OP_SRCH_INC:  a <= a_p1[KW-1:0];
      OP_SETB:      b <= stat.srch_end ? '0 : a_p1[KW-1:0];
      OP_RDB:       ka <= rd_key;
      OP_CAPB:      kb <= rd_key;
      OP_SETUP: begin
        dur_r <= (dur_c <= 33'sd0) ? ONE_Q : dur_c[31:0];
        num_r <= num_c;
      end
      OP_SDIRECT:   s <= (num_r <= 33'sd0) ? 17'd0 : 17'(ONE_Q);
      OP_SQUO:      s <= div_quo[16:0];
      OP_SM1:       s2 <= sq[32:16];
      OP_SM2: begin
        sm <= smp[32:16];
        ch <= '0;
      end
      OP_CH_D: begin
        d_r  <= d_c;
        wpos <= pos_c;
        wneg <= neg_c;
        x_r  <= m_c[33:16];
      end
      OP_CH_Q:   qe <= qx[31:22];
      OP_CH_W:   dw_r <= dw_c[32:0];
      OP_CH_MUL: prodc <= dw_r * $signed({1'b0, sm});
      OP_CH_WR:  ch <= ch + 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    stat.item_cmd  = item_cmd;
    stat.enable    = enable;
    stat.loop_mode = loop_mode;
    stat.div_fin   = div_fin;
    stat.n_zero    = key_count == '0;
    stat.n_one     = key_count == CW'(1);
    stat.srch_end  = a_p1 == (CW+1)'(key_count);
    stat.t_lt      = t < rd_key.t;
    stat.s_direct  = (num_r <= 33'sd0) || (num_r >= $signed({1'b0, dur_r}));
    stat.ch_last   = ch == CH_FOV;
  end

  assign pos_x      = pose[0];
  assign pos_y      = pose[1];
  assign pos_z      = pose[2];
  assign out_pitch  = pose[3];
  assign out_yaw    = pose[4];
  assign out_roll   = pose[5];
  assign out_fov    = pose[6];
  assign slot_index = slot;
  assign add_ok     = ok;

endmodule
`default_nettype wire

// ----- hdl/keyframe_camera_interpolator.sv -----
// Add, clear, restart and a disabled tick pass from dispatch straight to the done state.
// A live tick waits on the divider at most twice, scans the keys for its segment
// and blends the pose channels one after another; clamp mode skips the time divide
// and an eased fraction of 0 or 1 skips the second one.
// Handshake: one word at a time; start is ignored while busy; done cannot be stalled.
// Reset (rst, synchronous): key count, time and pose (fov 90.0) cleared; config registers set to defaults.
`default_nettype none
module keyframe_camera_interpolator import kci_pkg::*; #(
  parameter int MAX_KEYS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // command handshake
  input  wire logic               start,
  output logic                    busy,
  output logic                    done,
  // config write port
  input  wire logic               wr_en,
  input  wire logic [1:0]         wr_index,
  input  wire logic [31:0]        wr_data,
  // input word
  input  wire logic [1:0]         cmd,
  input  wire logic [23:0]        frame_time,
  input  wire logic signed [31:0] key_x,
  input  wire logic signed [31:0] key_y,
  input  wire logic signed [31:0] key_z,
  input  wire logic signed [31:0] key_pitch,
  input  wire logic signed [31:0] key_yaw,
  input  wire logic signed [31:0] key_roll,
  input  wire logic signed [31:0] key_fov,
  input  wire logic [31:0]        key_time,
  // result word, valid while done is high
  output logic signed [31:0]      pos_x,
  output logic signed [31:0]      pos_y,
  output logic signed [31:0]      pos_z,
  output logic signed [31:0]      out_pitch,
  output logic signed [31:0]      out_yaw,
  output logic signed [31:0]      out_roll,
  output logic signed [31:0]      out_fov,
  output logic [3:0]              slot_index,
  output logic                    add_ok
);

  // Controller sequences one word through the datapath:
  // tick -> scale and accumulate time, wrap (divider) or clamp it,
  // scan keys for the segment, divide for the fraction, smoothstep,
  // then blend the seven pose channels one after another.
  kci_cmd_t  ctl;
  kci_stat_t stat;

  kci_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  // Datapath holds config, key table, accumulator, pose and the shared divider.
  kci_dp #(
    .MAX_KEYS (MAX_KEYS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .stat       (stat),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .cmd        (cmd),
    .frame_time (frame_time),
    .key_x      (key_x),
    .key_y      (key_y),
    .key_z      (key_z),
    .key_pitch  (key_pitch),
    .key_yaw    (key_yaw),
    .key_roll   (key_roll),
    .key_fov    (key_fov),
    .key_time   (key_time),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .out_pitch  (out_pitch),
    .out_yaw    (out_yaw),
    .out_roll   (out_roll),
    .out_fov    (out_fov),
    .slot_index (slot_index),
    .add_ok     (add_ok)
  );

endmodule
`default_nettype wire

// ----- hdl/kci_chk.sv -----
`default_nettype none
module kci_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [3:0]  slot_index,
  input wire logic        add_ok,
  input wire logic [31:0] out_fov
);

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done outside busy");

  a_done_last: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy after done");

  a_accept: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted word not taken");

  a_slot: assert property (@(posedge clk) disable iff (rst)
    (done && !add_ok) |-> (slot_index == 4'd0))
    else $error("slot set without add");

  a_pose_idle: assert property (@(posedge clk) disable iff (rst)
    (!busy && !$past(busy) && !$past(rst)) |-> $stable(out_fov))
    else $error("pose changed while idle");

endmodule

bind keyframe_camera_interpolator kci_chk u_kci_chk (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .slot_index (slot_index),
  .add_ok     (add_ok),
  .out_fov    (out_fov)
);
`default_nettype wire
